>>> rtl/ios_pkg.sv
package ios_pkg;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_MATCH   = 2'd0;
	localparam logic [1:0] KIND_UNHIT   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  entry_index;
		logic [31:0] entry_start;
		logic [31:0] entry_end;
		logic [7:0]  entry_label;
		logic [31:0] read_number;
		logic [31:0] read_begin;
		logic [31:0] read_end;
		logic        is_candidate;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  entry_number;
		logic [31:0] out_entry_start;
		logic [31:0] out_entry_end;
		logic [7:0]  out_entry_label;
		logic [31:0] out_read_number;
		logic [31:0] out_read_start;
		logic [31:0] out_read_end;
		logic [31:0] candidate_count;
		logic [31:0] match_count;
		logic [6:0]  unmatched_count;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] ent_start;
		logic [31:0] ent_end;
		logic [7:0]  ent_label;
	} ent_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FLUSH
	} ios_state_t;

endpackage

>>> rtl/interval_overlap_scan.sv
// Interval overlap scanner. A load item writes one entry (start, end, label) of a
// table of NUM_INTERVALS reference intervals; a load to a slot beyond the table is
// dropped. A query item with is_candidate set counts as a candidate and is compared,
// unsigned, against every entry in slot order; each overlapping entry gives one match
// item, marks the entry as hit and bumps the match count. A query with is_candidate
// clear, a load and request type 3 give no item. A report item lists every entry that
// was never hit with a running count, or one summary item when all entries were hit;
// it changes no state. Candidate and match counts saturate at all ones, and the final
// item of a request carries last. An entry must be loaded before a query or report
// reaches it. A load does not make the block busy. After taking a query or report the
// block stalls further requests until the request is closed: the table memory gives one
// entry per cycle while the result side does not stall and the single overlap comparator
// judges it, then a flush state closes the request. A result stall holds the scan
// only when an item is to move to the output register while that register still
// holds a stalled item. One finished item is kept back until the next is found, so
// that last can be set.
module interval_overlap_scan
	import ios_pkg::*;
#(
	parameter int NUM_INTERVALS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int IDX_W = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;

	ios_state_t state_q, state_d;

	// table memory and its registered read port
	ent_t ent_mem_q [NUM_INTERVALS];
	ent_t rd_ent_q;

	logic [IDX_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         rd_idx;
	logic                     rd_en;
	logic [NUM_INTERVALS-1:0] hit_q;
	logic                     is_query_q;
	logic [31:0]              rnum_q, rstart_q, rend_q;
	logic [31:0]              cand_q, match_q;
	logic [31:0]              cand_inc, match_inc;
	logic [6:0]               unm_q;
	res_t                     pend_q, res_q, row, push_row;
	logic                     pend_v_q, res_valid_q;

	logic req_take, start, query_start, load_we, out_free, cmp_hit, sel;
	logic take, advance, at_end, push_pend, push_last, push_sum;

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign req_take    = req_valid && !req_stall;
	assign query_start = req_take && req.req_type == REQ_QUERY && req.is_candidate;
	assign start       = query_start || (req_take && req.req_type == REQ_REPORT);
	assign load_we     = req_take && req.req_type == REQ_LOAD &&
		(7'(req.entry_index) < 7'(NUM_INTERVALS));
	assign out_free    = !res_valid_q || !res_stall;
	assign at_end      = (cnt_q == IDX_W'(NUM_INTERVALS - 1));
	assign cand_inc    = (cand_q == '1) ? cand_q : cand_q + 32'd1;
	assign match_inc   = (match_q == '1) ? match_q : match_q + 32'd1;

	ios_cmp u_cmp (
		.read_begin (rstart_q),
		.read_end   (rend_q),
		.ent_start  (rd_ent_q.ent_start),
		.ent_end    (rd_ent_q.ent_end),
		.hit        (cmp_hit)
	);

	assign sel = is_query_q ? cmp_hit : !hit_q[cnt_q];

	// result row for the entry now under the comparator
	always_comb begin
		row = '0;
		row.kind            = is_query_q ? KIND_MATCH : KIND_UNHIT;
		row.entry_number    = 7'(cnt_q) + 7'd1;
		row.out_entry_start = rd_ent_q.ent_start;
		row.out_entry_end   = rd_ent_q.ent_end;
		row.out_entry_label = rd_ent_q.ent_label;
		row.candidate_count = cand_q;
		if (is_query_q) begin
			row.out_read_number = rnum_q;
			row.out_read_start  = rstart_q;
			row.out_read_end    = rend_q;
			row.match_count     = match_inc;
		end else begin
			row.match_count     = match_q;
			row.unmatched_count = unm_q + 7'd1;
		end
	end

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		advance   = 1'b0;
		push_pend = 1'b0;
		push_last = 1'b0;
		push_sum  = 1'b0;
		rd_en     = 1'b0;
		rd_idx    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					rd_en   = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// hold while a kept-back item cannot leave
				if (!(sel && pend_v_q && !out_free)) begin
					advance   = 1'b1;
					take      = sel;
					push_pend = sel && pend_v_q;
					if (at_end) begin
						state_d = ST_FLUSH;
					end else begin
						rd_en  = 1'b1;
						rd_idx = cnt_q + 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (!((pend_v_q || !is_query_q) && !out_free)) begin
					push_last = pend_v_q;
					push_sum  = !pend_v_q && !is_query_q;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			ent_mem_q[req.entry_index[IDX_W-1:0]] <= '{req.entry_start, req.entry_end,
				req.entry_label};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ent_q <= ent_mem_q[rd_idx];
		end
	end

	// request fields and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			is_query_q <= 1'b0;
			hit_q      <= '0;
			cand_q     <= '0;
			match_q    <= '0;
			unm_q      <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			if (start) begin
				cnt_q      <= '0;
				is_query_q <= query_start;
				unm_q      <= '0;
				pend_v_q   <= 1'b0;
				if (query_start) begin
					cand_q <= cand_inc;
				end
			end
			if (advance && !at_end) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take) begin
				pend_v_q <= 1'b1;
				if (is_query_q) begin
					match_q       <= match_inc;
					hit_q[cnt_q]  <= 1'b1;
				end else begin
					unm_q <= unm_q + 7'd1;
				end
			end
			if (push_last) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rnum_q   <= req.read_number;
			rstart_q <= req.read_begin;
			rend_q   <= req.read_end;
		end
		if (take) begin
			pend_q <= row;
		end
	end

	// next output item: the kept-back one, the same closing the request, or the summary
	always_comb begin
		push_row = pend_q;
		if (push_sum) begin
			push_row                 = '0;
			push_row.kind            = KIND_SUMMARY;
			push_row.candidate_count = cand_q;
			push_row.match_count     = match_q;
			push_row.last            = 1'b1;
		end else if (push_last) begin
			push_row.last = 1'b1;
		end
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push_pend || push_last || push_sum) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend || push_last || push_sum) begin
			res_q <= push_row;
		end
	end

endmodule

>>> rtl/ios_cmp.sv
module ios_cmp
	import ios_pkg::*;
(
	input  logic [31:0] read_begin,
	input  logic [31:0] read_end,
	input  logic [31:0] ent_start,
	input  logic [31:0] ent_end,
	output logic        hit
);

	logic rs_ge_es, rs_le_ee, re_le_ee, re_ge_es;

	always_comb begin
		rs_ge_es = read_begin >= ent_start;
		rs_le_ee = read_begin <= ent_end;
		re_le_ee = read_end <= ent_end;
		re_ge_es = read_end >= ent_start;
		// start inside, read inside, end inside, or read covers entry
		hit = (rs_ge_es && rs_le_ee) || (rs_ge_es && re_le_ee) ||
			(re_ge_es && re_le_ee) || (!rs_ge_es && !re_le_ee) ||
			(read_begin == ent_start && !re_le_ee) ||
			(!rs_ge_es && read_end == ent_end);
	end

endmodule

>>> rtl/ios_checker.sv
module ios_checker
	import ios_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// a stalled item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result item changed");

	// the block only goes busy after taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_stall) |-> $past(req_valid))
		else $error("busy without an accepted item");

	// items are only produced while a request is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_stall))
		else $error("result item while idle");

	// a summary closes its report and names no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_SUMMARY |->
			res.last && res.entry_number == 7'd0 && res.unmatched_count == 7'd0)
		else $error("malformed summary item");

endmodule

bind interval_overlap_scan ios_checker u_ios_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
